// ----- rtl/dkts_pkg.sv -----
// Shared widths, limits and record type of the descending key/tag sorter.
package dkts_pkg;

  localparam int unsigned SCORE_W      = 16;
  localparam int unsigned TAG_W        = 7;
  localparam int unsigned LIMIT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 128;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7);
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(64);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ----- rtl/dkts_rec_if.sv -----
// Input record channel: valid/ready with score, tag and batch end flag.
interface dkts_rec_if
  import dkts_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] record_score;
  logic [TAG_W-1:0]   record_tag;
  logic               is_last;

  modport source (output valid, record_score, record_tag, is_last, input ready);
  modport sink   (input valid, record_score, record_tag, is_last, output ready);
endinterface

// ----- rtl/dkts_res_if.sv -----
// Result channel: valid/ready with ranked score, tag and batch flags.
interface dkts_res_if
  import dkts_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] sorted_score;
  logic [TAG_W-1:0]   sorted_tag;
  logic               last_result;
  logic               records_dropped;

  modport source (output valid, sorted_score, sorted_tag, last_result, records_dropped,
                  input ready);
  modport sink   (input valid, sorted_score, sorted_tag, last_result, records_dropped,
                  output ready);
endinterface

// ----- rtl/dkts_ram.sv -----
// Generic simple dual-port RAM, one write port, one read port, registered read.
module dkts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/descending_key_tag_sorter.sv -----
// Top level: record store, exchange sort over one RAM, ranked result output.
//
//  channel      dir  handshake                 payload
//  rec_i        in   valid/ready               record_score, record_tag, is_last
//  res_o        out  valid/ready               sorted_score, sorted_tag,
//                                              last_result, records_dropped
//  emit_limit   in   emit_limit_we_i (strobe)  emit_limit_i
//
//  Loading accepts one request per cycle while idle. After the last request, each
//  rank takes one pass: a pass start, then one RAM read per compared entry
//  from that rank to the last record held.
//  Only the emitted ranks are sorted. Input is stalled from the last request
//  until the final result sits in the output register.
//  Reset clears control state only; the RAM holds no reset value.
module descending_key_tag_sorter
  import dkts_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dkts_rec_if.sink           rec_i,
  dkts_res_if.source         res_o,
  input  logic               emit_limit_we_i,
  input  logic [LIMIT_W-1:0] emit_limit_i
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   nemit_q, nemit_d;
  logic [ADDR_W-1:0]  i_q, i_d;
  logic [ADDR_W-1:0]  j_q, j_d;
  rec_t               cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  rec_t               out_rec_q, out_rec_d;
  logic               out_last_q, out_last_d;
  logic               out_drop_q, out_drop_d;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  rec_t               ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  rec_t               ram_rdata;

  logic               rec_acc;
  logic [CNT_W-1:0]   count_inc;
  logic [LIMIT_W-1:0] lim_eff;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   lim_ext;
  logic [CNT_W-1:0]   i_nxt;
  logic [CNT_W-1:0]   j_nxt;
  logic               rank_last;
  logic               out_load;

  dkts_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rec_i.ready = (state_q == ST_IDLE);
  assign rec_acc     = rec_i.valid && rec_i.ready;

  assign count_inc = (count_q < CNT_W'(CAPACITY)) ? count_q + 1'b1 : count_q;

  always_comb begin
    priority if (limit_q == '0) begin
      lim_eff = LIMIT_MIN;
    end else if (limit_q > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = limit_q;
    end
  end

  assign cnt_ext   = CMP_W'(count_inc);
  assign lim_ext   = CMP_W'(lim_eff);
  assign i_nxt     = CNT_W'(i_q) + 1'b1;
  assign j_nxt     = CNT_W'(j_q) + 1'b1;
  assign rank_last = (i_nxt == nemit_q);
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    nemit_d     = nemit_q;
    i_d         = i_q;
    j_d         = j_q;
    cur_d       = cur_q;
    out_rec_d   = out_rec_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = j_q;
    ram_wdata   = cur_q;
    ram_raddr   = i_q;

    unique case (state_q)
      ST_IDLE: begin
        if (rec_acc) begin
          if (count_q < CNT_W'(CAPACITY)) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[ADDR_W-1:0];
            ram_wdata = '{score: rec_i.record_score, tag: rec_i.record_tag};
          end else begin
            ovf_d = 1'b1;
          end
          count_d = count_inc;
          if (rec_i.is_last) begin
            n_d     = count_inc;
            nemit_d = (cnt_ext < lim_ext) ? count_inc : CNT_W'(lim_ext);
            i_d     = '0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        ram_raddr = i_q;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        cur_d     = ram_rdata;
        ram_raddr = i_nxt[ADDR_W-1:0];
        j_d       = i_nxt[ADDR_W-1:0];
        state_d   = (i_nxt < n_q) ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (ram_rdata.score > cur_q.score) begin
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = cur_q;
          cur_d     = ram_rdata;
        end
        if (j_nxt < n_q) begin
          ram_raddr = j_nxt[ADDR_W-1:0];
          j_d       = j_nxt[ADDR_W-1:0];
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_rec_d   = cur_q;
          out_last_d  = rank_last;
          out_drop_d  = ovf_q;
          if (rank_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_nxt[ADDR_W-1:0];
            state_d = ST_START;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (emit_limit_we_i) begin
        limit_q <= emit_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nemit_q    <= nemit_d;
    i_q        <= i_d;
    j_q        <= j_d;
    cur_q      <= cur_d;
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.sorted_score    = out_rec_q.score;
  assign res_o.sorted_tag      = out_rec_q.tag;
  assign res_o.last_result     = out_last_q;
  assign res_o.records_dropped = out_drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("record count beyond capacity");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (nemit_q != '0) && (nemit_q <= n_q) && (CNT_W'(i_q) < nemit_q))
    else $error("rank outside emit range");

  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(j_q) < n_q) && (j_q > i_q))
    else $error("scan address outside pass window");

  a_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rank_last) |=> (state_q == ST_IDLE) && (count_q == '0) && !ovf_q)
    else $error("batch state not cleared after final rank");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !rec_i.ready)
    else $error("input taken during sort");

endmodule
